// File: rtl/pfge_pkg.sv
// Shared types, sizes and command codes of the Pauli frame gate engine.
package pfge_pkg;

	// Sizes of the frame table and of the measurement record.
	localparam int QUBITS = 256;
	localparam int QB_W   = $clog2(QUBITS);
	localparam int LANES  = 64;
	localparam int DEPTH  = 256;
	localparam int REC_W  = $clog2(DEPTH);
	localparam int CNT_W  = REC_W + 1;

	// Lanes that are kept; the upper bits of every word stay zero.
	localparam logic [63:0] LANE_MASK = {64{1'b1}} >> (64 - LANES);

	// Command codes.
	localparam logic [4:0] CMD_HXZ       = 5'd0;
	localparam logic [4:0] CMD_HXY       = 5'd1;
	localparam logic [4:0] CMD_HYZ       = 5'd2;
	localparam logic [4:0] CMD_CX        = 5'd3;
	localparam logic [4:0] CMD_CY        = 5'd4;
	localparam logic [4:0] CMD_CZ        = 5'd5;
	localparam logic [4:0] CMD_SWAP      = 5'd6;
	localparam logic [4:0] CMD_ISWAP     = 5'd7;
	localparam logic [4:0] CMD_XCX       = 5'd8;
	localparam logic [4:0] CMD_XCY       = 5'd9;
	localparam logic [4:0] CMD_XCZ       = 5'd10;
	localparam logic [4:0] CMD_YCX       = 5'd11;
	localparam logic [4:0] CMD_YCY       = 5'd12;
	localparam logic [4:0] CMD_YCZ       = 5'd13;
	localparam logic [4:0] CMD_MEAS      = 5'd14;
	localparam logic [4:0] CMD_RESET     = 5'd15;
	localparam logic [4:0] CMD_MEASRESET = 5'd16;
	localparam logic [4:0] CMD_IDENTITY  = 5'd17;
	localparam logic [4:0] CMD_FLIP      = 5'd18;

	// Error codes.
	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_EDIT     = 2'd1;
	localparam logic [1:0] ERR_LOOKBACK = 2'd2;

	// One gate request.
	typedef struct packed {
		logic [4:0]  command;
		logic [7:0]  qubit_a;
		logic [7:0]  qubit_b;
		logic        a_from_record;
		logic        b_from_record;
		logic [8:0]  lookback;
		logic [63:0] random_word;
		logic        flip_x;
		logic        flip_z;
	} req_t;

	// One result.
	typedef struct packed {
		logic [63:0] measured_word;
		logic        is_measurement;
		logic [1:0]  error_code;
	} rsp_t;

	// One row of the frame table.
	typedef struct packed {
		logic [63:0] x;
		logic [63:0] z;
	} row_t;

	// A row write seen by the request that was read at the same edge.
	typedef struct packed {
		logic            en;
		logic [QB_W-1:0] addr;
		row_t            row;
	} fwd_t;

endpackage

// File: rtl/pauli_frame_gate_engine.sv
// Pauli frame gate engine: frame table, measurement record and gate datapath.
//
// The engine accepts one gate request per clock cycle while it does not stall, and returns
// one result per request, in order, in the cycle after the request leaves its single work
// stage. The frame table is held in two row banks, each with one write port and two read
// ports; a per-row bank select bit and a per-row valid bit (cleared by reset, so an
// unwritten row reads as zero) pick the latest copy, and a one-deep bypass covers a row
// written at the edge it is read. The measurement record is a ring with one write and one
// read port, bypassed the same way. No clearing pass is needed after reset. The request
// side stalls only while the work stage holds a request that the stalled output register
// cannot yet take.
module pauli_frame_gate_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  pfge_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output pfge_pkg::rsp_t   rsp
);
	import pfge_pkg::*;

	// Storage.
	row_t        bank_a_mem [QUBITS];
	row_t        bank_b_mem [QUBITS];
	logic [63:0] rec_mem [DEPTH];
	logic [QUBITS-1:0] row_valid_q;
	logic [QUBITS-1:0] row_lvt_q;
	logic [REC_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;

	// Work stage.
	logic        s1_valid_q;
	req_t        req_s1;
	row_t        a_qa_s1, a_qb_s1, b_qa_s1, b_qb_s1;
	logic        vld_qa_s1, vld_qb_s1, lvt_qa_s1, lvt_qb_s1;
	fwd_t        fwd_a_s1, fwd_b_s1;
	logic [63:0] rec_rd_s1, rec_fwd_s1;
	logic        rec_hit_s1;

	// Output register.
	logic out_valid_q;
	rsp_t rsp_q;

	// Handshake and addressing.
	logic             accept, s1_adv, push_now;
	logic [QB_W-1:0]  qa_in, qb_in, qa_s1, qb_s1;
	logic [REC_W-1:0] head_eff, rd_slot;

	// Datapath.
	row_t        row_a_mem, row_b_mem, row1, row2, n1, n2;
	logic [63:0] x1, z1, x2, z2, rnd, m, y1, y2, dx;
	logic        ra, rb, lb_bad, ctl_on_a, rc, rt, ctl_y;
	logic        wa_en, wb_en, ism;
	logic [1:0]  err;

	assign s1_adv    = s1_valid_q & (~out_valid_q | ~rsp_stall);
	assign req_stall = s1_valid_q & ~s1_adv;
	assign accept    = req_valid & ~req_stall;

	assign qa_in = req.qubit_a[QB_W-1:0];
	assign qb_in = req.qubit_b[QB_W-1:0];
	assign qa_s1 = req_s1.qubit_a[QB_W-1:0];
	assign qb_s1 = req_s1.qubit_b[QB_W-1:0];

	// Record read slot, counted from the head as it stands after this edge.
	assign push_now = s1_adv & ism;
	assign head_eff = head_q + REC_W'(push_now);
	assign rd_slot  = head_eff - req.lookback[REC_W-1:0];

	// Pick the latest copy of each operand row, with bypass of the write at the read edge.
	always_comb begin
		row_a_mem = vld_qa_s1 ? (lvt_qa_s1 ? b_qa_s1 : a_qa_s1) : '0;
		row_b_mem = vld_qb_s1 ? (lvt_qb_s1 ? b_qb_s1 : a_qb_s1) : '0;
		if (fwd_b_s1.en && fwd_b_s1.addr == qa_s1) begin
			row1 = fwd_b_s1.row;
		end else if (fwd_a_s1.en && fwd_a_s1.addr == qa_s1) begin
			row1 = fwd_a_s1.row;
		end else begin
			row1 = row_a_mem;
		end
		if (fwd_b_s1.en && fwd_b_s1.addr == qb_s1) begin
			row2 = fwd_b_s1.row;
		end else if (fwd_a_s1.en && fwd_a_s1.addr == qb_s1) begin
			row2 = fwd_a_s1.row;
		end else begin
			row2 = row_b_mem;
		end
	end

	// Operand words and lookback check.
	assign x1     = row1.x;
	assign z1     = row1.z;
	assign x2     = row2.x;
	assign z2     = row2.z;
	assign y1     = x1 ^ z1;
	assign y2     = x2 ^ z2;
	assign dx     = x1 ^ x2;
	assign rnd    = req_s1.random_word & LANE_MASK;
	assign m      = (rec_hit_s1 ? rec_fwd_s1 : rec_rd_s1) & LANE_MASK;
	assign ra     = req_s1.a_from_record;
	assign rb     = req_s1.b_from_record;
	assign lb_bad = (req_s1.lookback == '0) || (req_s1.lookback > count_q);

	// Controlled gates with a possible record control: which side holds the control.
	assign ctl_on_a = (req_s1.command == CMD_CX) || (req_s1.command == CMD_CY);
	assign rc       = ctl_on_a ? ra : rb;
	assign rt       = ctl_on_a ? rb : ra;
	assign ctl_y    = (req_s1.command == CMD_CY) || (req_s1.command == CMD_YCZ);

	// Gate decode and new row words.
	always_comb begin
		n1    = row1;
		n2    = row2;
		wa_en = 1'b0;
		wb_en = 1'b0;
		ism   = 1'b0;
		err   = ERR_OK;
		unique case (req_s1.command) inside
			CMD_HXZ, CMD_HXY, CMD_HYZ, CMD_MEAS, CMD_RESET, CMD_MEASRESET, CMD_FLIP: begin
				if (ra) begin
					err = ERR_EDIT;
				end else begin
					wa_en = 1'b1;
					case (req_s1.command)
						CMD_HXZ: begin
							n1.x = z1;
							n1.z = x1;
						end
						CMD_HXY: n1.z = z1 ^ x1;
						CMD_HYZ: n1.x = x1 ^ z1;
						CMD_MEAS: begin
							ism  = 1'b1;
							n1.z = rnd;
						end
						CMD_RESET: begin
							n1.x = '0;
							n1.z = rnd;
						end
						CMD_MEASRESET: begin
							ism  = 1'b1;
							n1.x = '0;
							n1.z = rnd;
						end
						default: begin
							if (req_s1.flip_x) n1.x = x1 ^ rnd;
							if (req_s1.flip_z) n1.z = z1 ^ rnd;
						end
					endcase
				end
			end
			CMD_CX, CMD_CY, CMD_XCZ, CMD_YCZ: begin
				if (rt) begin
					err = ERR_EDIT;
				end else if (rc) begin
					// Control comes from the record: only the target row changes.
					if (lb_bad) begin
						err = ERR_LOOKBACK;
					end else if (ctl_on_a) begin
						wb_en = 1'b1;
						n2.x  = x2 ^ m;
						if (ctl_y) n2.z = z2 ^ m;
					end else begin
						wa_en = 1'b1;
						n1.x  = x1 ^ m;
						if (ctl_y) n1.z = z1 ^ m;
					end
				end else begin
					wa_en = 1'b1;
					wb_en = 1'b1;
					case (req_s1.command)
						CMD_CX: begin
							n1.z = z1 ^ z2;
							n2.x = x2 ^ x1;
						end
						CMD_CY: begin
							n1.z = z1 ^ x2 ^ z2;
							n2.z = z2 ^ x1;
							n2.x = x2 ^ x1;
						end
						CMD_XCZ: begin
							n2.z = z2 ^ z1;
							n1.x = x1 ^ x2;
						end
						default: begin
							n2.z = z2 ^ x1 ^ z1;
							n1.z = z1 ^ x2;
							n1.x = x1 ^ x2;
						end
					endcase
				end
			end
			CMD_CZ: begin
				if (ra && rb) begin
					// Both operands are records: nothing to do.
				end else if (ra || rb) begin
					if (lb_bad) begin
						err = ERR_LOOKBACK;
					end else if (ra) begin
						wb_en = 1'b1;
						n2.z  = z2 ^ m;
					end else begin
						wa_en = 1'b1;
						n1.z  = z1 ^ m;
					end
				end else begin
					wa_en = 1'b1;
					wb_en = 1'b1;
					n1.z  = z1 ^ x2;
					n2.z  = z2 ^ x1;
				end
			end
			CMD_SWAP, CMD_ISWAP, CMD_XCX, CMD_XCY, CMD_YCX, CMD_YCY: begin
				if (ra || rb) begin
					err = ERR_EDIT;
				end else begin
					wa_en = 1'b1;
					wb_en = 1'b1;
					case (req_s1.command)
						CMD_SWAP: begin
							n1 = row2;
							n2 = row1;
						end
						CMD_ISWAP: begin
							n1.z = z2 ^ dx;
							n2.z = z1 ^ dx;
							n1.x = x2;
							n2.x = x1;
						end
						CMD_XCX: begin
							n1.x = x1 ^ z2;
							n2.x = x2 ^ z1;
						end
						CMD_XCY: begin
							n1.x = x1 ^ x2 ^ z2;
							n2.x = x2 ^ z1;
							n2.z = z2 ^ z1;
						end
						CMD_YCX: begin
							n2.x = x2 ^ x1 ^ z1;
							n1.x = x1 ^ z2;
							n1.z = z1 ^ z2;
						end
						default: begin
							n1.x = x1 ^ y2;
							n1.z = z1 ^ y2;
							n2.x = x2 ^ y1;
							n2.z = z2 ^ y1;
						end
					endcase
				end
			end
			default: begin
				// Identity and unused codes change nothing.
			end
		endcase
	end

	// Row bank A: takes the first operand's new row.
	always_ff @(posedge clk) begin
		if (s1_adv && wa_en) begin
			bank_a_mem[qa_s1] <= n1;
		end
		if (accept) begin
			a_qa_s1 <= bank_a_mem[qa_in];
			a_qb_s1 <= bank_a_mem[qb_in];
		end
	end

	// Row bank B: takes the second operand's new row.
	always_ff @(posedge clk) begin
		if (s1_adv && wb_en) begin
			bank_b_mem[qb_s1] <= n2;
		end
		if (accept) begin
			b_qa_s1 <= bank_b_mem[qa_in];
			b_qb_s1 <= bank_b_mem[qb_in];
		end
	end

	// Measurement record ring.
	always_ff @(posedge clk) begin
		if (push_now) begin
			rec_mem[head_q] <= x1;
		end
		if (accept) begin
			rec_rd_s1 <= rec_mem[rd_slot];
		end
	end

	// Work stage payload, row status samples and bypass of the writes at this edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1          <= req;
			vld_qa_s1       <= row_valid_q[qa_in];
			vld_qb_s1       <= row_valid_q[qb_in];
			lvt_qa_s1       <= row_lvt_q[qa_in];
			lvt_qb_s1       <= row_lvt_q[qb_in];
			fwd_a_s1.en     <= s1_adv & wa_en;
			fwd_a_s1.addr   <= qa_s1;
			fwd_a_s1.row    <= n1;
			fwd_b_s1.en     <= s1_adv & wb_en;
			fwd_b_s1.addr   <= qb_s1;
			fwd_b_s1.row    <= n2;
			rec_hit_s1      <= push_now & (rd_slot == head_q);
			rec_fwd_s1      <= x1;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.measured_word  <= ism ? x1 : '0;
			rsp_q.is_measurement <= ism;
			rsp_q.error_code     <= err;
		end
	end

	// Control state: stage occupancy, row status bits and record pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			row_valid_q <= '0;
			row_lvt_q   <= '0;
			head_q      <= '0;
			count_q     <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			// A second-operand write to the same row wins over the first.
			if (s1_adv && wa_en) begin
				row_valid_q[qa_s1] <= 1'b1;
				row_lvt_q[qa_s1]   <= 1'b0;
			end
			if (s1_adv && wb_en) begin
				row_valid_q[qb_s1] <= 1'b1;
				row_lvt_q[qb_s1]   <= 1'b1;
			end
			if (push_now) begin
				head_q <= head_q + 1'b1;
				if (count_q != CNT_W'(DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench of the Pauli frame gate engine: predictor, scoreboard and stimulus.
`timescale 1ns / 100ps

module tb_top;
	import pfge_pkg::*;

	// Codes outside the defined command set; the engine treats them as identity.
	localparam logic [4:0] CMD_UNUSED_FIRST = 5'd19;
	localparam logic [4:0] CMD_UNUSED_LAST  = 5'd31;

	// Cycles without any handshake before the run is declared hung.
	localparam int HANG_LIMIT = 5000;
	localparam int RANDOM_PER_PHASE = 431;

	// Frame predictor and ordered store of expected results.
	class frame_scoreboard;
		logic [63:0] x_words[QUBITS];
		logic [63:0] z_words[QUBITS];
		logic [63:0] record_words[DEPTH];
		int          record_head;
		int          record_fill;
		rsp_t        outcome_q[$];
		int          failures;
		int          n_requests;
		int          n_checked;
		int          n_measured;
		int          n_errors;

		function new();
			for (int i = 0; i < QUBITS; i++) begin
				x_words[i] = '0;
				z_words[i] = '0;
			end
			foreach (record_words[i]) record_words[i] = '0;
			record_head = 0;
			record_fill = 0;
			failures    = 0;
			n_requests  = 0;
			n_checked   = 0;
			n_measured  = 0;
			n_errors    = 0;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		// A lookback is usable only when it reaches an entry that has been written.
		function bit lookback_ok(logic [8:0] lb);
			return (lb != 0) && (lb <= record_fill);
		endfunction

		function logic [63:0] record_at(logic [8:0] lb);
			return record_words[(record_head + DEPTH - lb) % DEPTH];
		endfunction

		// Two-qubit gate on frame rows; row b is written last, so it wins on aliasing.
		function void apply_pair(logic [4:0] cmd, int qa, int qb);
			logic [63:0] x1, z1, x2, z2, n1x, n1z, n2x, n2z, y1, y2, dx;
			x1 = x_words[qa];
			z1 = z_words[qa];
			x2 = x_words[qb];
			z2 = z_words[qb];
			n1x = x1;
			n1z = z1;
			n2x = x2;
			n2z = z2;
			y1 = x1 ^ z1;
			y2 = x2 ^ z2;
			dx = x1 ^ x2;
			case (cmd)
				CMD_CX: begin
					n1z = z1 ^ z2;
					n2x = x2 ^ x1;
				end
				CMD_CY: begin
					n1z = z1 ^ x2 ^ z2;
					n2z = z2 ^ x1;
					n2x = x2 ^ x1;
				end
				CMD_CZ: begin
					n1z = z1 ^ x2;
					n2z = z2 ^ x1;
				end
				CMD_SWAP: begin
					n1x = x2;
					n1z = z2;
					n2x = x1;
					n2z = z1;
				end
				CMD_ISWAP: begin
					n1z = z2 ^ dx;
					n2z = z1 ^ dx;
					n1x = x2;
					n2x = x1;
				end
				CMD_XCX: begin
					n1x = x1 ^ z2;
					n2x = x2 ^ z1;
				end
				CMD_XCY: begin
					n1x = x1 ^ x2 ^ z2;
					n2x = x2 ^ z1;
					n2z = z2 ^ z1;
				end
				CMD_XCZ: begin
					n2z = z2 ^ z1;
					n1x = x1 ^ x2;
				end
				CMD_YCX: begin
					n2x = x2 ^ x1 ^ z1;
					n1x = x1 ^ z2;
					n1z = z1 ^ z2;
				end
				CMD_YCY: begin
					n1x = x1 ^ y2;
					n1z = z1 ^ y2;
					n2x = x2 ^ y1;
					n2z = z2 ^ y1;
				end
				default: begin
					// YCZ: control is qubit b, target is qubit a.
					n2z = z2 ^ x1 ^ z1;
					n1z = z1 ^ x2;
					n1x = x1 ^ x2;
				end
			endcase
			x_words[qa] = n1x & LANE_MASK;
			z_words[qa] = n1z & LANE_MASK;
			x_words[qb] = n2x & LANE_MASK;
			z_words[qb] = n2z & LANE_MASK;
		endfunction

		// Updates the frame for one accepted request and queues the result it should give.
		function void apply_gate(req_t r);
			rsp_t        want;
			int          qa, qb, tgt;
			logic [63:0] x1, z1, n1x, n1z, rnd, ctl;
			bit          forward, ctl_rec, tgt_rec;
			want = '0;
			qa   = r.qubit_a % QUBITS;
			qb   = r.qubit_b % QUBITS;
			rnd  = r.random_word & LANE_MASK;
			x1   = x_words[qa];
			z1   = z_words[qa];
			n1x  = x1;
			n1z  = z1;
			n_requests++;
			case (r.command)
				CMD_HXZ, CMD_HXY, CMD_HYZ, CMD_MEAS, CMD_RESET, CMD_MEASRESET, CMD_FLIP: begin
					if (r.a_from_record) begin
						want.error_code = ERR_EDIT;
					end else begin
						case (r.command)
							CMD_HXZ: begin
								n1x = z1;
								n1z = x1;
							end
							CMD_HXY: n1z = z1 ^ x1;
							CMD_HYZ: n1x = x1 ^ z1;
							CMD_MEAS: begin
								want.measured_word  = x1;
								want.is_measurement = 1'b1;
								n1z = rnd;
							end
							CMD_RESET: begin
								n1x = '0;
								n1z = rnd;
							end
							CMD_MEASRESET: begin
								want.measured_word  = x1;
								want.is_measurement = 1'b1;
								n1x = '0;
								n1z = rnd;
							end
							default: begin
								if (r.flip_x) n1x = x1 ^ rnd;
								if (r.flip_z) n1z = z1 ^ rnd;
							end
						endcase
						// A measurement goes into the ring, overwriting the oldest when full.
						if (want.is_measurement) begin
							record_words[record_head] = x1 & LANE_MASK;
							record_head = (record_head + 1) % DEPTH;
							if (record_fill < DEPTH) record_fill++;
						end
						x_words[qa] = n1x & LANE_MASK;
						z_words[qa] = n1z & LANE_MASK;
					end
				end
				CMD_CX, CMD_CY, CMD_XCZ, CMD_YCZ: begin
					// XCZ and YCZ are CX and CY with control and target swapped.
					forward = (r.command == CMD_CX) || (r.command == CMD_CY);
					ctl_rec = forward ? r.a_from_record : r.b_from_record;
					tgt_rec = forward ? r.b_from_record : r.a_from_record;
					tgt     = forward ? qb : qa;
					if (tgt_rec) begin
						want.error_code = ERR_EDIT;
					end else if (ctl_rec) begin
						if (!lookback_ok(r.lookback)) begin
							want.error_code = ERR_LOOKBACK;
						end else begin
							ctl = record_at(r.lookback) & LANE_MASK;
							x_words[tgt] ^= ctl;
							if (r.command == CMD_CY || r.command == CMD_YCZ)
								z_words[tgt] ^= ctl;
						end
					end else begin
						apply_pair(r.command, qa, qb);
					end
				end
				CMD_CZ: begin
					// Two record operands do nothing and the lookback is not looked at.
					if (r.a_from_record && r.b_from_record) begin
						want.error_code = ERR_OK;
					end else if (r.a_from_record || r.b_from_record) begin
						if (!lookback_ok(r.lookback)) begin
							want.error_code = ERR_LOOKBACK;
						end else begin
							tgt = r.a_from_record ? qb : qa;
							z_words[tgt] ^= record_at(r.lookback) & LANE_MASK;
						end
					end else begin
						apply_pair(r.command, qa, qb);
					end
				end
				CMD_SWAP, CMD_ISWAP, CMD_XCX, CMD_XCY, CMD_YCX, CMD_YCY: begin
					if (r.a_from_record || r.b_from_record)
						want.error_code = ERR_EDIT;
					else
						apply_pair(r.command, qa, qb);
				end
				default: begin
					// Identity and unused codes leave everything alone.
				end
			endcase
			if (want.is_measurement) n_measured++;
			if (want.error_code != ERR_OK) n_errors++;
			outcome_q.push_back(want);
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				failures++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		// Compares one delivered result against the oldest expectation.
		function void compare_outcome(rsp_t got);
			rsp_t want;
			if (outcome_q.size() == 0) begin
				failures++;
				$display("%0t: result with nothing expected, expected none, actual %h",
					$time, got);
				return;
			end
			want = outcome_q.pop_front();
			n_checked++;
			check_field("measured_word", want.measured_word, got.measured_word);
			check_field("is_measurement", 64'(want.is_measurement), 64'(got.is_measurement));
			check_field("error_code", 64'(want.error_code), 64'(got.error_code));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int sender_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	frame_scoreboard sb;

	pauli_frame_gate_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Output-side backpressure at the current stall rate.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Every delivered result is checked at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.compare_outcome(rsp);
	end

	// Hang detection: counts edges with no handshake on either side.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, sb.pending());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic req_t make_req(logic [4:0] cmd, int qa, int qb, bit ra, bit rb, int lb,
			logic [63:0] word, bit fx, bit fz);
		req_t r;
		r.command       = cmd;
		r.qubit_a       = qa[7:0];
		r.qubit_b       = qb[7:0];
		r.a_from_record = ra;
		r.b_from_record = rb;
		r.lookback      = lb[8:0];
		r.random_word   = word;
		r.flip_x        = fx;
		r.flip_z        = fz;
		return r;
	endfunction

	// Presents one request after a random idle gap and holds it until taken.
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.apply_gate(r);
		@(negedge clk);
	endtask

	// Holds off new requests until every outstanding result is back.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	initial begin
		int          depth, pick, qa, qb, lb;
		logic [4:0]  cmd;
		logic [63:0] word;
		sb              = new();
		quiet_cycles    = 0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		rsp_stall       = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: seed some lanes, then every gate, the record paths and the error cases.
		send_request(make_req(CMD_FLIP, 0, 0, 0, 0, 0, '1, 1, 0));
		send_request(make_req(CMD_FLIP, 255, 0, 0, 1, 0, 64'hA5A5_0F0F_3C3C_FFFF, 1, 1));
		send_request(make_req(CMD_HXZ, 0, 0, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_HXY, 255, 0, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_HYZ, 0, 0, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_MEAS, 255, 0, 0, 0, 0, 64'h1234_5678_9ABC_DEF0, 0, 0));
		send_request(make_req(CMD_CX, 9, 3, 1, 0, 1, '0, 0, 0));
		send_request(make_req(CMD_CX, 9, 3, 1, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_CX, 0, 3, 0, 1, 1, '0, 0, 0));
		send_request(make_req(CMD_CY, 0, 3, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_CZ, 0, 1, 1, 1, 0, '0, 0, 0));
		send_request(make_req(CMD_CZ, 7, 1, 1, 0, 1, '0, 0, 0));
		send_request(make_req(CMD_CZ, 0, 7, 0, 1, 1, '0, 0, 0));
		send_request(make_req(CMD_SWAP, 0, 255, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_ISWAP, 0, 3, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_XCX, 3, 3, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_XCY, 0, 1, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_XCZ, 0, 255, 0, 1, 1, '0, 0, 0));
		send_request(make_req(CMD_YCX, 255, 0, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_YCY, 0, 255, 0, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_YCZ, 3, 0, 0, 1, 1, '0, 0, 0));
		send_request(make_req(CMD_MEASRESET, 0, 0, 0, 0, 0, 64'hFEDC_BA98_7654_3210, 0, 0));
		send_request(make_req(CMD_RESET, 255, 0, 0, 0, 0, '1, 0, 0));
		send_request(make_req(CMD_IDENTITY, 0, 1, 1, 1, 0, '1, 1, 1));
		send_request(make_req(CMD_UNUSED_LAST, 0, 1, 0, 0, 0, '1, 1, 1));
		send_request(make_req(CMD_HXZ, 0, 0, 1, 0, 0, '0, 0, 0));
		send_request(make_req(CMD_MEAS, 0, 0, 0, 0, 0, '0, 0, 0));
		drain_results();

		// Random phases: free flow, sparse sender, heavy backpressure, then both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Flips inject lanes, measurements fill the ring and unused codes act as identity; the rest are gates.
				pick = $urandom_range(99);
				if (pick < 4)
					cmd = 5'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
				else if (pick < 18)
					cmd = CMD_FLIP;
				else if (pick < 32)
					cmd = 5'($urandom_range(CMD_MEASRESET, CMD_MEAS));
				else
					cmd = 5'($urandom_range(CMD_IDENTITY, CMD_HXZ));
				// Most gates work a small pool of qubits so that lanes interact.
				qa = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(7);
				qb = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(7);
				if ($urandom_range(19) == 0) qb = qa;
				// Lookbacks are mostly valid, with edges and junk mixed in.
				depth = sb.record_fill;
				case ($urandom_range(9))
					0: lb = 0;
					1: lb = depth + 1;
					2: lb = $urandom_range(511);
					3: lb = DEPTH;
					4: lb = (depth == 0) ? 1 : depth;
					default: lb = (depth == 0) ? 1 : $urandom_range(depth, 1);
				endcase
				case ($urandom_range(7))
					0: word = '1;
					1: word = '0;
					default: word = {$urandom, $urandom};
				endcase
				send_request(make_req(cmd, qa, qb, $urandom_range(99) < 15,
					$urandom_range(99) < 15, lb, word, $urandom_range(1), $urandom_range(1)));
			end
			drain_results();
		end

		// Let more edges pass so that a stray extra result would be seen.
		repeat (8) @(posedge clk);
		if (sb.pending() != 0) sb.failures++;
		$display("Ran %0d gate requests over four handshake phases, %0d results checked.",
			sb.n_requests, sb.n_checked);
		$display("Results held %0d measurements and %0d error codes; record depth reached %0d.",
			sb.n_measured, sb.n_errors, sb.record_fill);
		if (sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: pauli_frame_gate_engine.f
rtl/pfge_pkg.sv
rtl/pauli_frame_gate_engine.sv
sim/tb_top.sv
